### hw/rtl/rmpwq_pkg.sv
// Shared types and constants for the recursive mutex lock unit.
`default_nettype none
package rmpwq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_W        = 8;
  localparam int PRIO_W      = 8;
  localparam int NEST_W      = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam logic [NEST_W-1:0] NEST_MAX = 16'd65535;

  // request kinds carried in s_tuser
  typedef enum logic [1:0] {
    REQ_LOCK    = 2'd0,
    REQ_TRYLOCK = 2'd1,
    REQ_UNLOCK  = 2'd2,
    REQ_DESTROY = 2'd3
  } req_t;

  // result codes carried in m_tuser
  typedef enum logic [2:0] {
    ST_ACQUIRED = 3'd0,
    ST_NESTED   = 3'd1,
    ST_QUEUED   = 3'd2,
    ST_FAILED   = 3'd3,
    ST_FULL     = 3'd4,
    ST_RELEASED = 3'd5,
    ST_HANDED   = 3'd6,
    ST_WOKEN    = 3'd7
  } status_t;

  // queue operation broadcast along the cell row
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   ins;
  } cell_ctrl_t;

  // top-level sequencer states
  typedef enum logic [1:0] {
    FSM_IDLE  = 2'b01,
    FSM_DRAIN = 2'b10
  } fsm_t;

endpackage
`default_nettype wire

### hw/rtl/rmpwq_cell.sv
// One wait-queue slot: holds an entry, inserts, shifts from neighbors.
`default_nettype none
module rmpwq_cell (
  input  wire                     clk,
  input  rmpwq_pkg::cell_ctrl_t   ctrl,
  input  wire                     occ,        // slot lies below the fill count
  input  wire                     prev_keep,  // slot above stays in place
  input  rmpwq_pkg::entry_t       prev_ent,
  input  rmpwq_pkg::entry_t       next_ent,
  output rmpwq_pkg::entry_t       ent,
  output logic                    keep
);

  rmpwq_pkg::entry_t ent_next;

  // entry is ahead of a new one of this priority (FIFO among equals)
  assign keep = occ && (ent.prio <= ctrl.ins.prio);

  always_comb begin
    ent_next = ent;
    unique case (ctrl.op)
      rmpwq_pkg::OP_INSERT: begin
        if (keep) begin
          ent_next = ent;
        end else if (prev_keep) begin
          ent_next = ctrl.ins;
        end else begin
          ent_next = prev_ent;
        end
      end
      rmpwq_pkg::OP_POP: ent_next = next_ent;
      default:           ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule
`default_nettype wire

### hw/rtl/rmpwq_chain.sv
// Row of queue cells kept sorted by priority; head is slot zero.
`default_nettype none
module rmpwq_chain (
  input  wire                               clk,
  input  rmpwq_pkg::cell_ctrl_t             ctrl,
  input  wire [rmpwq_pkg::CNT_W-1:0]        count,
  output rmpwq_pkg::entry_t                 head
);

  localparam int QD = rmpwq_pkg::QUEUE_DEPTH;

  rmpwq_pkg::entry_t ent  [QD];
  logic              keep [QD];

  for (genvar i = 0; i < QD; i++) begin : g_cell
    logic              occ;
    logic              prev_keep;
    rmpwq_pkg::entry_t prev_ent;
    rmpwq_pkg::entry_t next_ent;

    assign occ = (rmpwq_pkg::CNT_W'(i) < count);

    // front slot sees the new entry as its upstream neighbor
    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
      assign prev_ent  = ctrl.ins;
    end else begin : g_mid
      assign prev_keep = keep[i-1];
      assign prev_ent  = ent[i-1];
    end

    if (i == QD - 1) begin : g_last
      assign next_ent = ent[i];
    end else begin : g_inner
      assign next_ent = ent[i+1];
    end

    rmpwq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ),
      .prev_keep (prev_keep),
      .prev_ent  (prev_ent),
      .next_ent  (next_ent),
      .ent       (ent[i]),
      .keep      (keep[i])
    );
  end

  assign head = ent[0];

endmodule
`default_nettype wire

### hw/rtl/recursive_mutex_priority_wait_queue.sv
// Recursive mutex lock unit with a priority-ordered wait queue (top level).
// Results are registered: a request's result appears on the master port in the cycle after its beat is accepted.
// Throughput: one request per cycle while m_tready is high and no destroy drain
//   is running; insert and pop are done by the cell row in parallel.
// Destroy with N waiters gives N result beats, one per cycle while m_tready is high, input held off meanwhile.
// Reset (rst, synchronous): mutex free, owner 0, nest 0, queue empty; no clearing pass.
`default_nettype none
module recursive_mutex_priority_wait_queue (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [7:0] thread_id, [15:8] thread_prio
  input  wire  [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // [7:0] woken_thread, [23:8] nest_count
  output logic [3:0]  m_tuser,   // [2:0] status, [3] woken_valid
  output logic        m_tlast    // last
);

  localparam int CW = rmpwq_pkg::CNT_W;
  localparam int NW = rmpwq_pkg::NEST_W;
  localparam int IW = rmpwq_pkg::ID_W;

  // control state
  rmpwq_pkg::fsm_t  state, state_next;
  logic             locked, locked_next;
  logic [IW-1:0]    owner, owner_next;
  logic [NW-1:0]    nest, nest_next;
  logic [CW-1:0]    count, count_next;

  // output register
  rmpwq_pkg::status_t o_status, o_status_next;
  logic               o_wv, o_wv_next;
  logic [IW-1:0]      o_wt, o_wt_next;
  logic [NW-1:0]      o_nc, o_nc_next;
  logic               o_last, o_last_next;
  logic               o_load;

  rmpwq_pkg::cell_ctrl_t ctrl;
  rmpwq_pkg::entry_t     head;
  rmpwq_pkg::req_t       req;
  logic [IW-1:0]         in_id;
  logic                  accept, slot_free, q_full;
  logic [NW-1:0]         nest_inc, nest_dec;

  assign req       = rmpwq_pkg::req_t'(s_tuser);
  assign in_id     = s_tdata[7:0];
  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == rmpwq_pkg::FSM_IDLE) && slot_free;
  assign accept    = s_tvalid && s_tready;
  assign q_full    = (count == CW'(rmpwq_pkg::QUEUE_DEPTH));
  assign nest_inc  = (nest == rmpwq_pkg::NEST_MAX) ? nest : nest + NW'(1);
  assign nest_dec  = (nest == '0) ? nest : nest - NW'(1);

  rmpwq_chain u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .count (count),
    .head  (head)
  );

  // request decode and queue control
  always_comb begin
    state_next    = state;
    locked_next   = locked;
    owner_next    = owner;
    nest_next     = nest;
    count_next    = count;
    o_load        = 1'b0;
    o_status_next = o_status;
    o_wv_next     = 1'b0;
    o_wt_next     = '0;
    o_nc_next     = nest;
    o_last_next   = 1'b1;
    ctrl.op       = rmpwq_pkg::OP_HOLD;
    ctrl.ins.id   = in_id;
    ctrl.ins.prio = s_tdata[15:8];

    if (accept) begin
      o_load = 1'b1;
      unique case (req)
        rmpwq_pkg::REQ_LOCK: begin
          if (!locked) begin
            locked_next   = 1'b1;
            owner_next    = in_id;
            nest_next     = NW'(1);
            o_status_next = rmpwq_pkg::ST_ACQUIRED;
            o_nc_next     = NW'(1);
          end else if (owner == in_id) begin
            nest_next     = nest_inc;
            o_status_next = rmpwq_pkg::ST_NESTED;
            o_nc_next     = nest_inc;
          end else if (q_full) begin
            o_status_next = rmpwq_pkg::ST_FULL;
          end else begin
            ctrl.op       = rmpwq_pkg::OP_INSERT;
            count_next    = count + CW'(1);
            o_status_next = rmpwq_pkg::ST_QUEUED;
          end
        end
        rmpwq_pkg::REQ_TRYLOCK: begin
          if (!locked) begin
            locked_next   = 1'b1;
            owner_next    = in_id;
            nest_next     = NW'(1);
            o_status_next = rmpwq_pkg::ST_ACQUIRED;
            o_nc_next     = NW'(1);
          end else begin
            o_status_next = rmpwq_pkg::ST_FAILED;
          end
        end
        rmpwq_pkg::REQ_UNLOCK: begin
          if (!locked) begin
            o_status_next = rmpwq_pkg::ST_RELEASED;
            o_nc_next     = '0;
          end else if (owner != in_id) begin
            o_status_next = rmpwq_pkg::ST_FAILED;
          end else if (nest_dec != '0) begin
            nest_next     = nest_dec;
            o_status_next = rmpwq_pkg::ST_RELEASED;
            o_nc_next     = nest_dec;
          end else if (count == '0) begin
            locked_next   = 1'b0;
            owner_next    = '0;
            nest_next     = '0;
            o_status_next = rmpwq_pkg::ST_RELEASED;
            o_nc_next     = '0;
          end else begin
            // hand over to the queue head
            ctrl.op       = rmpwq_pkg::OP_POP;
            count_next    = count - CW'(1);
            owner_next    = head.id;
            nest_next     = NW'(1);
            o_status_next = rmpwq_pkg::ST_HANDED;
            o_wv_next     = 1'b1;
            o_wt_next     = head.id;
            o_nc_next     = NW'(1);
          end
        end
        default: begin
          // destroy: owner state clears now, waiters drain one beat a cycle while the output slot is free
          locked_next = 1'b0;
          owner_next  = '0;
          nest_next   = '0;
          o_nc_next   = '0;
          if (count == '0) begin
            o_status_next = rmpwq_pkg::ST_RELEASED;
          end else begin
            ctrl.op       = rmpwq_pkg::OP_POP;
            count_next    = count - CW'(1);
            o_status_next = rmpwq_pkg::ST_WOKEN;
            o_wv_next     = 1'b1;
            o_wt_next     = head.id;
            o_last_next   = (count == CW'(1));
            if (count != CW'(1)) begin
              state_next = rmpwq_pkg::FSM_DRAIN;
            end
          end
        end
      endcase
    end else if (state == rmpwq_pkg::FSM_DRAIN && slot_free) begin
      // wake remaining waiters in queue order
      o_load        = 1'b1;
      ctrl.op       = rmpwq_pkg::OP_POP;
      count_next    = count - CW'(1);
      o_status_next = rmpwq_pkg::ST_WOKEN;
      o_wv_next     = 1'b1;
      o_wt_next     = head.id;
      o_nc_next     = '0;
      o_last_next   = (count == CW'(1));
      if (count == CW'(1)) begin
        state_next = rmpwq_pkg::FSM_IDLE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rmpwq_pkg::FSM_IDLE;
      locked   <= 1'b0;
      owner    <= '0;
      nest     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      locked <= locked_next;
      owner  <= owner_next;
      nest   <= nest_next;
      count  <= count_next;
      if (o_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (o_load) begin
      o_status <= o_status_next;
      o_wv     <= o_wv_next;
      o_wt     <= o_wt_next;
      o_nc     <= o_nc_next;
      o_last   <= o_last_next;
    end
  end

  assign m_tdata = {o_nc, o_wt};
  assign m_tuser = {o_wv, o_status};
  assign m_tlast = o_last;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(rmpwq_pkg::QUEUE_DEPTH))
    else $error("wait queue count beyond depth");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == rmpwq_pkg::FSM_DRAIN |-> count != '0)
    else $error("draining an empty queue");

  a_lock_nest: assert property (@(posedge clk) disable iff (rst)
    locked == (nest != '0))
    else $error("nest count disagrees with lock flag");

  a_free_owner: assert property (@(posedge clk) disable iff (rst)
    !locked |-> owner == '0)
    else $error("free mutex keeps an owner");
`endif

endmodule
`default_nettype wire
